// ===== src/height_map_gradient_macros.svh =====
// Assertion macros for the height map gradient block.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef HEIGHT_MAP_GRADIENT_MACROS_SVH
`define HEIGHT_MAP_GRADIENT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HMG_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("height_map_gradient: check failed");

// next-cycle implication
`define HMG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("height_map_gradient: check failed");

`else

`define HMG_ASSERT_IMPLIES(label, ante, cons)
`define HMG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/hmg_pkg.sv =====
// Shared constants, types and helpers for the height map gradient block.
// No dependencies; used by every module of the block except hmg_ram.
package hmg_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int CFG_W         = 13;
    localparam int PIX_W         = 8;
    localparam int GRAD_W        = 10;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    typedef enum logic
    {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_type_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // one pending result: neighbors fetched by the front, window finished by the back
    typedef struct packed {
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
        logic [PIX_W-1:0] first;
        logic             col_first;
        logic             col_last;
        logic             row_first;
        logic             row_last;
        logic             frame_last;
    } hmg_entry_t;

    typedef struct packed {
        logic       push;
        hmg_entry_t entry;
    } push_bus_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
        hmg_entry_t        head;
    } queue_stat_t;

    // clamp a dimension register to [2, hi] and return it minus one
    function automatic logic [COL_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] c;
        c = v;
        if (v < CFG_W'(2))
            c = CFG_W'(2);
        else if (v > hi)
            c = hi;
        return COL_W'(c - CFG_W'(1));
    endfunction

    function automatic logic signed [GRAD_W-1:0] pix_diff(input logic [PIX_W-1:0] a,
                                                          input logic [PIX_W-1:0] b);
        logic [GRAD_W-1:0] d;
        d = {{(GRAD_W-PIX_W){1'b0}}, a} - {{(GRAD_W-PIX_W){1'b0}}, b};
        return signed'(d);
    endfunction

endpackage

// ===== src/hmg_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
module hmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // a read at the address being written returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[wr_addr] <= wr_data;
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/hmg_front.sv =====
// Front end: input handshake, frame position tracking, config registers and
// the two line buffers. Emits one queue entry per result. Depends on hmg_pkg, hmg_ram.
module hmg_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [hmg_pkg::PIX_W-1:0]    height,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [hmg_pkg::CFG_W-1:0]    cfg_data,
    input  logic [hmg_pkg::QCNT_W-1:0]   q_count,
    output hmg_pkg::push_bus_t           push_bus
);
    import hmg_pkg::*;

    typedef struct packed {
        logic             par;
        logic [PIX_W-1:0] lower;
        logic [PIX_W-1:0] first;
        logic             col_first;
        logic             col_last;
        logic             row_first;
        logic             row_last;
        logic             frame_last;
    } s2_meta_t;

    logic [COL_W-1:0] wlast_reg, wlast_next;
    logic [ROW_W-1:0] hlast_reg, hlast_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic             full_reg, full_next;
    logic [PIX_W-1:0] first_reg;
    logic             s2_valid_reg;
    s2_meta_t         s2_reg, s2_next;

    logic             accept;
    logic             is_flush;
    logic             emit;
    logic             wr_en;
    logic             col_last;
    logic [QCNT_W:0]  occupancy;
    logic [COL_W-1:0] right_addr;
    logic [COL_W-1:0] ram0_rd_addr;
    logic [COL_W-1:0] ram1_rd_addr;
    logic [PIX_W-1:0] ram0_q;
    logic [PIX_W-1:0] ram1_q;

    // reserve a queue slot for the beat in stage 2 and for the one accepted now
    assign occupancy = {1'b0, q_count} + {{QCNT_W{1'b0}}, s2_valid_reg};
    assign in_stall  = occupancy >= (QCNT_W+1)'(QDEPTH);
    assign accept    = in_valid && !in_stall;
    assign is_flush  = (req_type_t'(req_type) == REQ_FLUSH);
    assign cfg_ready = 1'b1;
    assign col_last  = in_col_reg >= wlast_reg;

    always_comb
    begin
        wlast_next  = wlast_reg;
        hlast_next  = hlast_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        full_next   = full_reg;
        emit        = 1'b0;
        wr_en       = 1'b0;

        s2_next            = s2_reg;
        s2_next.lower      = height;
        s2_next.first      = first_reg;
        s2_next.col_first  = (in_col_reg == '0);
        s2_next.col_last   = col_last;
        s2_next.row_first  = 1'b0;
        s2_next.row_last   = 1'b0;
        s2_next.frame_last = 1'b0;
        s2_next.par        = ~in_row_reg[0];

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                    wlast_next = dim_last(cfg_data, CFG_W'(MAX_WIDTH));
                REG_IMAGE_HEIGHT:
                    hlast_next = ROW_W'(dim_last(cfg_data, CFG_W'(MAX_HEIGHT)));
                default:
                    wlast_next = wlast_reg;
            endcase
            in_col_next = '0;
            in_row_next = '0;
            full_next   = 1'b0;
        end
        else if (accept)
        begin
            if (full_reg)
            begin
                // drain of the last row; in_col counts the drained columns
                emit               = 1'b1;
                s2_next.par        = hlast_reg[0];
                s2_next.row_last   = 1'b1;
                s2_next.frame_last = col_last;
                if (col_last)
                begin
                    in_col_next = '0;
                    in_row_next = '0;
                    full_next   = 1'b0;
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
            else if (!is_flush)
            begin
                wr_en             = 1'b1;
                emit              = (in_row_reg != '0);
                s2_next.row_first = (in_row_reg == ROW_W'(1));
                if (col_last)
                begin
                    in_col_next = '0;
                    if (in_row_reg >= hlast_reg)
                    begin
                        full_next   = 1'b1;
                        in_row_next = '0;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end
        end
    end

    // right neighbor comes from the current output row, upper from the other buffer
    assign right_addr   = in_col_reg + COL_W'(1);
    assign ram0_rd_addr = s2_next.par ? in_col_reg : right_addr;
    assign ram1_rd_addr = s2_next.par ? right_addr : in_col_reg;

    hmg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line0 (
        .clk     (clk),
        .we      (wr_en && !in_row_reg[0]),
        .wr_addr (in_col_reg),
        .wr_data (height),
        .rd_addr (ram0_rd_addr),
        .rd_data (ram0_q)
    );

    hmg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line1 (
        .clk     (clk),
        .we      (wr_en && in_row_reg[0]),
        .wr_addr (in_col_reg),
        .wr_data (height),
        .rd_addr (ram1_rd_addr),
        .rd_data (ram1_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg    <= COL_W'(WIDTH_RESET - 1);
            hlast_reg    <= ROW_W'(HEIGHT_RESET - 1);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            full_reg     <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            wlast_reg    <= wlast_next;
            hlast_reg    <= hlast_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            full_reg     <= full_next;
            s2_valid_reg <= accept && emit && !cfg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            s2_reg <= s2_next;
        if (accept && !full_reg && !is_flush && (in_col_reg == '0))
            first_reg <= height;
    end

    always_comb
    begin
        push_bus.push             = s2_valid_reg;
        push_bus.entry.right      = s2_reg.par ? ram1_q : ram0_q;
        push_bus.entry.upper      = s2_reg.par ? ram0_q : ram1_q;
        push_bus.entry.lower      = s2_reg.lower;
        push_bus.entry.first      = s2_reg.first;
        push_bus.entry.col_first  = s2_reg.col_first;
        push_bus.entry.col_last   = s2_reg.col_last;
        push_bus.entry.row_first  = s2_reg.row_first;
        push_bus.entry.row_last   = s2_reg.row_last;
        push_bus.entry.frame_last = s2_reg.frame_last;
    end

endmodule

// ===== src/hmg_queue.sv =====
// Short FIFO between the front end and the gradient back end.
// Depends on hmg_pkg.
module hmg_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hmg_pkg::push_bus_t    push_bus,
    input  logic                  pop,
    output hmg_pkg::queue_stat_t  q_stat
);
    import hmg_pkg::*;

    hmg_entry_t        entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_bus.push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
            count_next  = count_next + QCNT_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
            count_next  = count_next - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_bus.push)
            entry_reg[wr_ptr_reg] <= push_bus.entry;
    end

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.count = count_reg;
    assign q_stat.head  = entry_reg[rd_ptr_reg];

endmodule

// ===== src/hmg_back.sv =====
// Back end: completes the 3-wide row window, forms both differences and
// holds the result in the output register. Depends on hmg_pkg.
module hmg_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hmg_pkg::queue_stat_t               q_stat,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hmg_pkg::GRAD_W-1:0]  grad_x,
    output logic signed [hmg_pkg::GRAD_W-1:0]  grad_y,
    output logic                               frame_last
);
    import hmg_pkg::*;

    hmg_entry_t               e;
    logic [PIX_W-1:0]         cur;
    logic [PIX_W-1:0]         prev_right_reg;
    logic [PIX_W-1:0]         prev_cur_reg;
    logic                     out_valid_reg, out_valid_next;
    logic signed [GRAD_W-1:0] gx_reg, gx_next;
    logic signed [GRAD_W-1:0] gy_reg, gy_next;
    logic                     last_reg;

    assign e   = q_stat.head;
    // the current pixel was the right neighbor of the previous beat, except at column 0
    assign cur = e.col_first ? e.first : prev_right_reg;
    assign pop = q_stat.valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        priority if (e.col_first)
            gx_next = pix_diff(cur, e.right) <<< 1;
        else if (e.col_last)
            gx_next = pix_diff(prev_cur_reg, cur) <<< 1;
        else
            gx_next = pix_diff(prev_cur_reg, e.right);

        priority if (e.row_first)
            gy_next = pix_diff(cur, e.lower) <<< 1;
        else if (e.row_last)
            gy_next = pix_diff(e.upper, cur) <<< 1;
        else
            gy_next = pix_diff(e.upper, e.lower);

        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prev_right_reg <= e.right;
            prev_cur_reg   <= cur;
            gx_reg         <= gx_next;
            gy_reg         <= gy_next;
            last_reg       <= e.frame_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign grad_x     = gx_reg;
    assign grad_y     = gy_reg;
    assign frame_last = last_reg;

endmodule

// ===== src/height_map_gradient.sv =====
// Height map gradient: pixels in raster order, one result per pixel once the
// pixel below has arrived (flush beats drain the last row). Sustained rate is
// one item per clock when not stalled: each line buffer RAM takes one read and
// one write per cycle. A result passes through the stage 2 register, the queue
// and the output register. Line buffers are 2 x 4096 x 8 bit, not cleared; no
// startup pass. Config writes restart the frame and must only be issued while
// the block is idle; the block itself does not enforce this. Depends on
// hmg_pkg, hmg_front, hmg_queue, hmg_back and the assertion macros.
`include "height_map_gradient_macros.svh"

module height_map_gradient (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [hmg_pkg::PIX_W-1:0]          height,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [hmg_pkg::GRAD_W-1:0]  grad_x,
    output logic signed [hmg_pkg::GRAD_W-1:0]  grad_y,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [hmg_pkg::CFG_W-1:0]          cfg_data
);
    import hmg_pkg::*;

    push_bus_t   push_bus;
    queue_stat_t q_stat;
    logic        pop;

    hmg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .height    (height),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_stat.count),
        .push_bus  (push_bus)
    );

    hmg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_bus (push_bus),
        .pop      (pop),
        .q_stat   (q_stat)
    );

    hmg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .frame_last (frame_last)
    );

    `HMG_ASSERT_IMPLIES(a_push_has_room, push_bus.push, (q_stat.count < QCNT_W'(QDEPTH)) || pop)
    `HMG_ASSERT_IMPLIES(a_pop_has_data, pop, q_stat.valid)
    `HMG_ASSERT_NEXT(a_pop_loads_output, pop, out_valid)

endmodule
